// ----- rtl/itp_pkg.sv -----
// shared types, character codes and rank function for the infix-to-postfix converter
package itp_pkg;

    // default operator stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // expression outcome codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNMATCHED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // class of the held input character
    typedef enum logic [1:0] {
        K_DIGIT,
        K_OPEN,
        K_CLOSE,
        K_OPER
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic emit_char;
        logic emit_top;
        logic emit_end;
        logic push;
        logic drop_top;
        logic set_unmatched;
    } itp_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  count_zero;
        logic  top_open;
        logic  pop_ok;
        logic  err_any;
        logic  last;
        logic  out_free;
    } itp_status_t;

    // operator rank: parentheses 0, + - 1, * / 2, anything else -1
    function automatic logic signed [2:0] rank_of(input logic [7:0] c);
        logic signed [2:0] r;
        case (c)
            CH_OPEN, CH_CLOSE: r = 3'sd0;
            CH_PLUS, CH_MINUS: r = 3'sd1;
            CH_MUL, CH_DIV:    r = 3'sd2;
            default:           r = -3'sd1;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/itp_datapath.sv -----
// datapath: held input character, operator stack, error latch and output register
module itp_datapath import itp_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  itp_cmd_t    cmd,
    output itp_status_t stat,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        has_char,
    output logic        expr_end,
    output logic [1:0]  status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0]    char_reg;
    logic          last_reg;
    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    top_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    err_reg, err_next;
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          has_char_reg;
    logic          expr_end_reg;
    logic [1:0]    status_reg;

    logic [CW-1:0] top_pos;
    logic [CW-1:0] below_pos;
    logic [7:0]    top_char;
    logic          full;
    logic          emit_any;

    // stack top held in a register, entry below it read on a pop
    assign top_pos   = count_reg - CW'(1);
    assign below_pos = count_reg - CW'(2);
    assign top_char  = top_reg;
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign emit_any  = cmd.emit_char | cmd.emit_top | cmd.emit_end;

    // status towards the controller
    always_comb begin
        if (char_reg >= CH_ZERO && char_reg <= CH_NINE) begin
            stat.kind = K_DIGIT;
        end else if (char_reg == CH_OPEN) begin
            stat.kind = K_OPEN;
        end else if (char_reg == CH_CLOSE) begin
            stat.kind = K_CLOSE;
        end else begin
            stat.kind = K_OPER;
        end
        stat.count_zero = (count_reg == '0);
        stat.top_open   = (top_char == CH_OPEN);
        stat.pop_ok     = (rank_of(char_reg) <= rank_of(top_char));
        stat.err_any    = (err_reg != ST_OK);
        stat.last       = last_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // next count and error latch
    always_comb begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.push) begin
            if (full) begin
                err_next   = ST_OVERFLOW;
                count_next = '0;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.emit_top || cmd.drop_top) begin
            count_next = top_pos;
        end
        if (cmd.set_unmatched) begin
            err_next = ST_UNMATCHED;
        end
        if (cmd.emit_end) begin
            err_next   = ST_OK;
            count_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            err_reg   <= err_next;
            if (emit_any) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input hold, stack write, top refresh and output word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        if (cmd.push && !full) begin
            stack_mem[count_reg[AW-1:0]] <= char_reg;
            top_reg                      <= char_reg;
        end else if (cmd.emit_top || cmd.drop_top) begin
            top_reg <= stack_mem[below_pos[AW-1:0]];
        end
        if (emit_any) begin
            out_char_reg <= cmd.emit_end ? 8'd0 : (cmd.emit_top ? top_char : char_reg);
            has_char_reg <= !cmd.emit_end;
            expr_end_reg <= cmd.emit_end;
            status_reg   <= cmd.emit_end ? err_reg : ST_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign has_char  = has_char_reg;
    assign expr_end  = expr_end_reg;
    assign status    = status_reg;

endmodule

// ----- rtl/itp_ctrl.sv -----
// controller state machine sequencing pushes, pops, flush and end marker
module itp_ctrl import itp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  itp_status_t stat,
    output itp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH,
        S_ENDM
    } state_t;

    state_t state_reg, state_next;
    state_t post_state;

    assign in_ready   = (state_reg == S_IDLE);
    assign post_state = stat.last ? S_FLUSH : S_IDLE;

    // command decode and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.err_any) begin
                    // rest of a failed expression is dropped
                    state_next = post_state;
                end else begin
                    case (stat.kind)
                        K_DIGIT: begin
                            if (stat.out_free) begin
                                cmd.emit_char = 1'b1;
                                state_next    = post_state;
                            end
                        end
                        K_OPEN: begin
                            cmd.push   = 1'b1;
                            state_next = post_state;
                        end
                        K_CLOSE: begin
                            if (stat.count_zero) begin
                                cmd.set_unmatched = 1'b1;
                                state_next        = post_state;
                            end else if (stat.top_open) begin
                                cmd.drop_top = 1'b1;
                                state_next   = post_state;
                            end else if (stat.out_free) begin
                                cmd.emit_top = 1'b1;
                            end
                        end
                        K_OPER: begin
                            if (!stat.count_zero && stat.pop_ok) begin
                                cmd.emit_top = stat.out_free;
                            end else begin
                                cmd.push   = 1'b1;
                                state_next = post_state;
                            end
                        end
                        default: begin
                            state_next = post_state;
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (stat.err_any || stat.count_zero) begin
                    state_next = S_ENDM;
                end else if (stat.out_free) begin
                    cmd.emit_top = 1'b1;
                end
            end
            S_ENDM: begin
                if (stat.out_free) begin
                    cmd.emit_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
// Infix-to-postfix converter top level: operator stack shunting-yard with stream ports
// A character is accepted only in the idle state and held; the execute state then
// emits it or pops stack entries to the output register before the next is accepted,
// and a last character is followed by a flush of the stack and the end marker.
// The single stack read port allows one pop per cycle while the output is not stalled.
// Reset (aresetn low, synchronous) empties the stack, clears the error latch and the
// output valid; stack contents are not cleared.
module infix_to_postfix_converter import itp_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [9:8] status, [15:10] zero
    output logic        m_tuser,   // [0] has_char
    output logic        m_tlast
);

    itp_cmd_t    cmd;
    itp_status_t stat;
    logic [7:0]  out_char;
    logic [1:0]  status;

    // control
    itp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack and output word
    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .has_char  (m_tuser),
        .expr_end  (m_tlast),
        .status    (status)
    );

    assign m_tdata = {6'd0, status, out_char};

endmodule

// ----- rtl/itp_checker.sv -----
// port-level checker for the infix-to-postfix converter, with its bind
module itp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // end marker carries no character
    a_end_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser && m_tdata[7:0] == 8'd0)
        else $error("end marker carries a character");

    // a word without character is always the end marker
    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("bare word that is not an end marker");

    // character words carry ok status, end markers never the unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser && m_tdata[9:8] == 2'd0)
                  || (!m_tuser && m_tdata[9:8] != 2'd3))
        else $error("bad status code");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled word changed");

    // no word straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- dv/tb.sv -----
// testbench for the infix-to-postfix converter: directed and random expressions checked word by word
`timescale 1ns / 1ps

module tb import itp_pkg::*; ();

    localparam int OPS_DEPTH   = STACK_DEPTH_DEF;
    localparam int RAND_CHARS  = 360;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;

    // one expression character waiting to be sent, or a pause marker
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;
    } char_item_t;

    // one postfix word as it should leave the block
    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       fin;
        logic [1:0] st;
    } postfix_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    char_item_t    char_q[$];
    postfix_word_t postfix_q[$];
    logic [7:0]    expr_buf[$];

    // predictor state
    logic [7:0] opstk [OPS_DEPTH];
    int         stk_cnt = 0;
    logic [1:0] err_st  = ST_OK;

    int            bad_cnt  = 0;
    int            cycles   = 0;
    int            fed_cnt  = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    bit            calm_s   = 1'b0;
    bit            calm_m   = 1'b0;
    char_item_t    nxt;
    postfix_word_t want;

    infix_to_postfix_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always #5 aclk = ~aclk;

    // operator precedence, parentheses lowest among the known ones
    function automatic int prec(input logic [7:0] c);
        int r;
        case (c)
            CH_OPEN, CH_CLOSE: r = 0;
            CH_PLUS, CH_MINUS: r = 1;
            CH_MUL, CH_DIV:    r = 2;
            default:           r = -1;
        endcase
        return r;
    endfunction

    task automatic queue_word(input logic [7:0] ch, input logic has, input logic fin,
                              input logic [1:0] st);
        postfix_word_t w;
        w.ch  = ch;
        w.has = has;
        w.fin = fin;
        w.st  = st;
        postfix_q.push_back(w);
    endtask

    task automatic pop_to_output();
        queue_word(opstk[stk_cnt - 1], 1'b1, 1'b0, ST_OK);
        stk_cnt--;
    endtask

    // push, or flag overflow and empty the stack
    task automatic push_op(input logic [7:0] c);
        if (stk_cnt >= OPS_DEPTH) begin
            err_st  = ST_OVERFLOW;
            stk_cnt = 0;
        end else begin
            opstk[stk_cnt] = c;
            stk_cnt++;
        end
    endtask

    // shunting-yard step for one accepted character
    task automatic convert_char(input logic [7:0] c, input logic last);
        if (err_st == ST_OK) begin
            if (c == CH_OPEN) begin
                push_op(c);
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                queue_word(c, 1'b1, 1'b0, ST_OK);
            end else if (c == CH_CLOSE) begin
                while (stk_cnt > 0 && opstk[stk_cnt - 1] != CH_OPEN)
                    pop_to_output();
                if (stk_cnt == 0)
                    err_st = ST_UNMATCHED;
                else
                    stk_cnt--;
            end else begin
                while (stk_cnt > 0 && prec(c) <= prec(opstk[stk_cnt - 1]))
                    pop_to_output();
                push_op(c);
            end
        end
        // flush and end marker on the last character
        if (last) begin
            if (err_st == ST_OK) begin
                while (stk_cnt > 0)
                    pop_to_output();
            end
            queue_word(8'd0, 1'b0, 1'b1, err_st);
            err_st  = ST_OK;
            stk_cnt = 0;
        end
    endtask

    // stimulus helpers
    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_oper();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = CH_PLUS;
            2, 3:    c = CH_MINUS;
            4, 5:    c = CH_MUL;
            6, 7:    c = CH_DIV;
            default: begin
                c = 8'($urandom_range(0, 255));
                while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_OPEN || c == CH_CLOSE)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            expr_buf.push_back(s[i]);
    endtask

    // balanced expression, now and then with open parentheses left over
    task automatic build_well_formed();
        int terms, open_n, k, t;
        terms  = $urandom_range(1, 6);
        open_n = 0;
        for (t = 0; t < terms; t++) begin
            k = $urandom_range(0, 2);
            while (k > 0 && open_n < 5) begin
                expr_buf.push_back(CH_OPEN);
                open_n++;
                k--;
            end
            repeat ($urandom_range(1, 2)) expr_buf.push_back(rand_digit());
            if (open_n > 0 && $urandom_range(0, 2) == 0) begin
                k = $urandom_range(1, open_n);
                repeat (k) expr_buf.push_back(CH_CLOSE);
                open_n -= k;
            end
            if (t < terms - 1)
                expr_buf.push_back(rand_oper());
        end
        if ($urandom_range(0, 4) != 0) begin
            repeat (open_n) expr_buf.push_back(CH_CLOSE);
        end
    endtask

    // move the buffered expression into the send queue, last flag on its final character
    task automatic commit_expr();
        char_item_t it;
        int i;
        for (i = 0; i < expr_buf.size(); i++) begin
            it.ch    = expr_buf[i];
            it.last  = (i == expr_buf.size() - 1);
            it.drain = 1'b0;
            char_q.push_back(it);
        end
        fed_cnt += expr_buf.size();
        expr_buf.delete();
    endtask

    task automatic add_drain();
        char_item_t it;
        it.ch    = 8'd0;
        it.last  = 1'b0;
        it.drain = 1'b1;
        char_q.push_back(it);
    endtask

    // input side driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                convert_char(s_tdata, s_tlast);
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (char_q.size() > 0 && char_q[0].drain) begin
                    // hold off until every pending word has come out
                    s_tvalid <= 1'b0;
                    if (postfix_q.size() == 0)
                        nxt = char_q.pop_front();
                end else if (char_q.size() > 0) begin
                    nxt = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.last;
                    if ($urandom_range(0, 39) == 0)
                        calm_s = !calm_s;
                    gap_left = calm_s ? 0 : $urandom_range(0, 15);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (postfix_q.size() == 0) begin
                    if (bad_cnt < 10)
                        $display("unexpected word: data %h user %b last %b",
                                 m_tdata, m_tuser, m_tlast);
                    bad_cnt++;
                end else begin
                    want = postfix_q.pop_front();
                    if (m_tdata !== {6'd0, want.st, want.ch} || m_tuser !== want.has ||
                        m_tlast !== want.fin) begin
                        if (bad_cnt < 10)
                            $display("mismatch: exp char %h has %b end %b st %0d, %s %h %b %b",
                                     want.ch, want.has, want.fin, want.st, "got",
                                     m_tdata, m_tuser, m_tlast);
                        bad_cnt++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    calm_m = !calm_m;
                stall_left = calm_m ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** infix_to_postfix_converter: FAILED **");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        // directed: all operators with parentheses
        add_text("(1+2)*3-4/5");
        commit_expr();
        // close parenthesis on an empty stack
        add_text(")");
        commit_expr();
        // nul and 0xff as low rank operators, open parenthesis left at the end
        expr_buf.push_back(8'h00);
        expr_buf.push_back(8'hFF);
        expr_buf.push_back(CH_OPEN);
        commit_expr();
        // unmatched close after a pop, rest of the expression dropped
        add_text("+)5");
        commit_expr();
        add_drain();

        // random part
        fed_cnt = 0;
        while (fed_cnt < RAND_CHARS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    build_well_formed();
                end
                12, 13: begin
                    // deep nesting towards and past a full stack
                    repeat ($urandom_range(14, 18)) expr_buf.push_back(CH_OPEN);
                    if ($urandom_range(0, 1) == 0)
                        expr_buf.push_back(CH_PLUS);
                    expr_buf.push_back(rand_digit());
                end
                14, 15: begin
                    // stray close parenthesis somewhere in a valid expression
                    build_well_formed();
                    expr_buf.insert($urandom_range(0, expr_buf.size()), CH_CLOSE);
                end
                default: begin
                    // noise bytes
                    repeat ($urandom_range(1, 8)) begin
                        if ($urandom_range(0, 2) == 0)
                            expr_buf.push_back($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
                        else
                            expr_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
            endcase
            commit_expr();
            if ($urandom_range(0, 11) == 0)
                add_drain();
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the queue to empty, then for the final word to be taken
        while (char_q.size() > 0) @(posedge aclk);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        while (postfix_q.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (bad_cnt == 0 && postfix_q.size() == 0) begin
            $display("** infix_to_postfix_converter: PASSED **");
        end else begin
            $display("** infix_to_postfix_converter: FAILED **");
        end
        $finish;
    end

endmodule
